[hdl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and silenced during reset.
`define PEA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle rule");

// Next-cycle implication, sampled on i_clk and silenced during reset.
`define PEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle rule");

`endif

[hdl/pea_pkg.sv]
// Types and constants of the palette entry allocator.
package pea_pkg;

    // Default palette depth.
    localparam int MAX_COLORS_DEF = 256;

    // Reference-count constants.
    localparam logic [31:0] RESERVED_REF   = 32'hf000_0000;
    localparam logic [31:0] SHARED_REF_INC = 32'h0000_f000;
    localparam logic [31:0] REF_ALL_ONES   = 32'hffff_ffff;
    localparam logic [31:0] REF_ONE        = 32'h0000_0001;

    // Colour of entry 0 after reset, and reset bit planes.
    localparam logic [7:0]  WHITE_LEVEL  = 8'hff;
    localparam logic [3:0]  PLANES_RESET = 4'd8;
    localparam logic [8:0]  TOP_LIMIT    = 9'd511;

    // Register index of the colour plane register.
    localparam logic [0:0]  REG_COLOR_PLANES = 1'b0;

    typedef enum logic [2:0] {
        ACT_ALLOC    = 3'd0,
        ACT_FREE     = 3'd1,
        ACT_FREE_ALL = 3'd2,
        ACT_GET      = 3'd3,
        ACT_CHANGE   = 3'd4,
        ACT_ADD      = 3'd5,
        ACT_RETAIN   = 3'd6,
        ACT_RELEASE  = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_WR,
        S_FREE_WR,
        S_FREE_TOP,
        S_FREE_ALL,
        S_GET,
        S_ADD_WR,
        S_ADJUST,
        S_DONE
    } t_state;

endpackage

[hdl/pea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/palette_entry_allocator.sv]
// Top level of the palette entry allocator: sequencer, used map and storage.
//
// One palette of up to MAX_COLORS entries. Each input word (action, index and
// colour) is taken on the input valid/ready channel and yields exactly one
// result word (status, value, colour) on the output valid/ready channel.
// The block takes one word at a time: input ready is high only while idle.
// Work per action, with n usable entries: alloc scans all n entries; retain
// and release sweep the entries below the top mark rounded up to 8, capped
// at n; free all walks down from below the top mark to the shared count;
// free may walk down from the freed entry to find the new top mark; get,
// change and add do no scan. The pace is set by the reference-count RAM, read
// one entry a cycle through one port, and by the one 32-bit adder that updates
// every count. A stalled receiver holds the result in the output register;
// the sequencer waits in its final state until the register is free and only
// then returns to idle. Synchronous reset restores entries 0 and 1 (white and
// black, reserved counts), a top mark and shared count of 2, and eight bit
// planes. The colour plane register is written through the APB port; the user
// must write it only while idle, as the block itself does not enforce this.
module palette_entry_allocator
    import pea_pkg::*;
#(
    parameter int MAX_COLORS = MAX_COLORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [8:0]  o_value,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam logic [8:0] MAX_N = 9'(MAX_COLORS);

    t_state r_state, n_state;

    logic [3:0]            r_planes;
    logic [MAX_COLORS-1:0] r_used, n_used;
    logic [MAX_COLORS-1:0] r_ref_vld, n_ref_vld;
    logic [1:0]            r_col_wr, n_col_wr;
    logic [8:0]            r_top, n_top;
    logic [8:0]            r_shared, n_shared;

    t_action     r_act, n_act;
    logic [7:0]  r_idx, n_idx;
    logic [23:0] r_rgb, n_rgb;
    logic [8:0]  r_k, n_k;
    logic        r_more, n_more;
    logic        r_pv, n_pv;
    logic [AW-1:0] r_pk, n_pk;
    logic [31:0] r_min, n_min;
    logic [AW-1:0] r_best, n_best;
    logic        r_found, n_found;
    logic [8:0]  r_cnt, n_cnt;

    logic        r_res_status, n_res_status;
    logic [8:0]  r_res_value, n_res_value;
    logic [23:0] r_res_rgb, n_res_rgb;

    logic        r_out_valid;
    logic        r_status;
    logic [8:0]  r_value;
    logic [23:0] r_rgb_out;

    // Memory ports.
    logic          ref_we;
    logic [AW-1:0] ref_waddr, ref_raddr;
    logic [31:0]   ref_q;
    logic          col_we;
    logic [AW-1:0] col_waddr, col_raddr;
    logic [23:0]   col_wdata, col_q;

    // Shared adder.
    logic [31:0] add_a, add_b, add_sum;

    logic       in_acc, out_free, cfg_wr;
    logic [3:0] planes_sat;
    logic [8:0] n_use;
    logic [9:0] lim_round;
    logic [8:0] adj_lim;
    logic       idx_ok, add_ok, fa_ok;
    logic [31:0] cnt_eff;
    logic [8:0]  cnt_new;
    logic [23:0] col_eff;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2:2] == REG_COLOR_PLANES);

    // Configuration port: one 4-bit register, always ready.
    assign pready = 1'b1;
    assign prdata = {28'd0, r_planes};

    // Usable entry count from the bit planes, capped at the palette depth.
    always_comb begin
        planes_sat = r_planes;
        if (r_planes < 4'd1) begin
            planes_sat = 4'd1;
        end else if (r_planes > 4'd8) begin
            planes_sat = 4'd8;
        end
        n_use = 9'd1 << planes_sat;
        if (n_use > MAX_N) begin
            n_use = MAX_N;
        end
    end

    // Sweep limit for retain and release.
    always_comb begin
        lim_round = ({1'b0, r_top} + 10'd7) & ~10'd7;
        adj_lim   = (lim_round > {1'b0, n_use}) ? n_use : lim_round[8:0];
    end

    assign idx_ok = ({1'b0, i_index} < n_use) && r_used[i_index[AW-1:0]];
    assign add_ok = r_shared < n_use;
    assign fa_ok  = r_top > r_shared;

    // Count read back from the RAM; entries never written read as their reset value.
    assign cnt_eff = r_ref_vld[r_pk] ? ref_q :
                     ((32'(r_pk) < 32'd2) ? RESERVED_REF : 32'd0);

    // Colour read back; entries 0 and 1 are white and black until written.
    always_comb begin
        col_eff = col_q;
        if ((32'(r_idx) < 32'd2) && !r_col_wr[r_idx[0]]) begin
            col_eff = r_idx[0] ? 24'd0 : {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
        end
    end

    // The one 32-bit adder that every count update goes through.
    always_comb begin
        add_a = cnt_eff;
        add_b = REF_ALL_ONES;
        unique case (r_state)
            S_ALLOC_WR: begin
                add_a = r_min;
                add_b = REF_ONE;
            end
            S_ADD_WR: add_b = SHARED_REF_INC;
            S_ADJUST: add_b = (r_act == ACT_RETAIN) ? REF_ONE : REF_ALL_ONES;
            default:  add_b = REF_ALL_ONES;
        endcase
        add_sum = add_a + add_b;
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_action'(i_action))
                        ACT_ALLOC:    n_state = S_ALLOC_SCAN;
                        ACT_FREE:     n_state = idx_ok ? S_FREE_WR : S_DONE;
                        ACT_FREE_ALL: n_state = fa_ok ? S_FREE_ALL : S_DONE;
                        ACT_GET:      n_state = idx_ok ? S_GET : S_DONE;
                        ACT_CHANGE:   n_state = S_DONE;
                        ACT_ADD:      n_state = add_ok ? S_ADD_WR : S_DONE;
                        ACT_RETAIN,
                        ACT_RELEASE:  n_state = (adj_lim != 9'd0) ? S_ADJUST : S_DONE;
                    endcase
                end
            end
            S_ALLOC_SCAN: begin
                if (!r_more && !r_pv) begin
                    n_state = S_ALLOC_WR;
                end
            end
            S_ALLOC_WR: n_state = S_DONE;
            S_FREE_WR: begin
                if (({1'b0, r_idx} + 9'd1 == r_top) && (r_idx != 8'd0)) begin
                    n_state = S_FREE_TOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE_TOP: begin
                if ((r_k == 9'd0) || r_used[r_k[AW-1:0]]) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_ALL: begin
                if (r_k == r_shared) begin
                    n_state = S_DONE;
                end
            end
            S_GET:    n_state = S_DONE;
            S_ADD_WR: n_state = S_DONE;
            S_ADJUST: begin
                if (!r_more && !r_pv) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        n_used       = r_used;
        n_ref_vld    = r_ref_vld;
        n_col_wr     = r_col_wr;
        n_top        = r_top;
        n_shared     = r_shared;
        n_act        = r_act;
        n_idx        = r_idx;
        n_rgb        = r_rgb;
        n_k          = r_k;
        n_more       = r_more;
        n_pv         = 1'b0;
        n_pk         = r_pk;
        n_min        = r_min;
        n_best       = r_best;
        n_found      = r_found;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_rgb    = r_res_rgb;
        cnt_new      = r_cnt;
        ref_we       = 1'b0;
        ref_waddr    = r_pk;
        ref_raddr    = r_k[AW-1:0];
        col_we       = 1'b0;
        col_waddr    = r_idx[AW-1:0];
        col_raddr    = r_idx[AW-1:0];
        col_wdata    = r_rgb;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act        = t_action'(i_action);
                    n_idx        = i_index;
                    n_rgb        = {i_red, i_green, i_blue};
                    n_res_status = 1'b0;
                    n_res_value  = 9'd0;
                    n_res_rgb    = 24'd0;
                    n_more       = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_ALLOC: begin
                            n_k     = n_use - 9'd1;
                            n_more  = 1'b1;
                            n_min   = REF_ALL_ONES;
                            n_found = 1'b0;
                        end
                        ACT_FREE: begin
                            ref_raddr = i_index[AW-1:0];
                            n_pk      = i_index[AW-1:0];
                            n_res_status = !idx_ok;
                        end
                        ACT_FREE_ALL: begin
                            n_k   = r_top - 9'd1;
                            n_cnt = 9'd0;
                        end
                        ACT_GET: begin
                            col_raddr    = i_index[AW-1:0];
                            n_res_status = !idx_ok;
                        end
                        ACT_CHANGE: begin
                            n_res_status = !idx_ok;
                            if (idx_ok) begin
                                col_we    = 1'b1;
                                col_waddr = i_index[AW-1:0];
                                col_wdata = {i_red, i_green, i_blue};
                                if (i_index < 8'd2) begin
                                    n_col_wr[i_index[0]] = 1'b1;
                                end
                            end
                        end
                        ACT_ADD: begin
                            n_res_status = !add_ok;
                            ref_raddr    = r_shared[AW-1:0];
                            n_pk         = r_shared[AW-1:0];
                            if (add_ok) begin
                                col_we    = 1'b1;
                                col_waddr = r_shared[AW-1:0];
                                col_wdata = {i_red, i_green, i_blue};
                                if (r_shared < 9'd2) begin
                                    n_col_wr[r_shared[0]] = 1'b1;
                                end
                            end
                        end
                        ACT_RETAIN,
                        ACT_RELEASE: begin
                            n_k    = adj_lim - 9'd1;
                            n_more = (adj_lim != 9'd0);
                        end
                    endcase
                end
            end
            S_ALLOC_SCAN: begin
                // Issue one read a cycle, compare the one that comes back.
                if (r_more) begin
                    n_pv = 1'b1;
                    n_pk = r_k[AW-1:0];
                    if (r_k == 9'd0) begin
                        n_more = 1'b0;
                    end else begin
                        n_k = r_k - 9'd1;
                    end
                end
                if (r_pv && !r_used[r_pk] && (cnt_eff < r_min)) begin
                    n_min   = cnt_eff;
                    n_best  = r_pk;
                    n_found = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                if (r_found) begin
                    col_we            = 1'b1;
                    col_waddr         = r_best;
                    ref_we            = 1'b1;
                    ref_waddr         = r_best;
                    n_used[r_best]    = 1'b1;
                    n_ref_vld[r_best] = 1'b1;
                    if (32'(r_best) < 32'd2) begin
                        n_col_wr[r_best[0]] = 1'b1;
                    end
                    if (9'(r_best) >= r_top) begin
                        n_top = 9'(r_best) + 9'd1;
                    end
                    n_res_value = 9'(r_best);
                end else begin
                    n_res_status = 1'b1;
                end
            end
            S_FREE_WR: begin
                ref_we          = 1'b1;
                n_used[r_pk]    = 1'b0;
                n_ref_vld[r_pk] = 1'b1;
                n_res_value     = 9'd1;
                if ({1'b0, r_idx} + 9'd1 == r_top) begin
                    if (r_idx == 8'd0) begin
                        n_top = 9'd0;
                    end else begin
                        n_k = {1'b0, r_idx} - 9'd1;
                    end
                end
            end
            S_FREE_TOP: begin
                // Walk down to the highest used entry above entry 0.
                if (r_k == 9'd0) begin
                    n_top = 9'd1;
                end else if (r_used[r_k[AW-1:0]]) begin
                    n_top = r_k + 9'd1;
                end else begin
                    n_k = r_k - 9'd1;
                end
            end
            S_FREE_ALL: begin
                if ((r_k < MAX_N) && r_used[r_k[AW-1:0]]) begin
                    n_used[r_k[AW-1:0]] = 1'b0;
                    cnt_new = r_cnt + 9'd1;
                end
                n_cnt = cnt_new;
                if (r_k == r_shared) begin
                    n_top       = r_shared;
                    n_res_value = cnt_new;
                end else begin
                    n_k = r_k - 9'd1;
                end
            end
            S_GET: begin
                n_res_rgb = col_eff;
            end
            S_ADD_WR: begin
                ref_we          = 1'b1;
                n_used[r_pk]    = 1'b1;
                n_ref_vld[r_pk] = 1'b1;
                n_shared        = r_shared + 9'd1;
                n_res_value     = r_shared;
                if (r_top < TOP_LIMIT) begin
                    n_top = r_top + 9'd1;
                end
            end
            S_ADJUST: begin
                if (r_more) begin
                    n_pv = 1'b1;
                    n_pk = r_k[AW-1:0];
                    if (r_k == 9'd0) begin
                        n_more = 1'b0;
                    end else begin
                        n_k = r_k - 9'd1;
                    end
                end
                if (r_pv && r_used[r_pk]) begin
                    ref_we          = 1'b1;
                    n_ref_vld[r_pk] = 1'b1;
                end
            end
            S_DONE: begin
                n_more = 1'b0;
            end
            default: begin
                n_more = 1'b0;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_planes    <= PLANES_RESET;
            r_used      <= MAX_COLORS'(2'b11);
            r_ref_vld   <= '0;
            r_col_wr    <= 2'b00;
            r_top       <= 9'd2;
            r_shared    <= 9'd2;
            r_more      <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_ref_vld <= n_ref_vld;
            r_col_wr  <= n_col_wr;
            r_top     <= n_top;
            r_shared  <= n_shared;
            r_more    <= n_more;
            r_pv      <= n_pv;
            if (cfg_wr) begin
                r_planes <= pwdata[3:0];
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_idx        <= n_idx;
        r_rgb        <= n_rgb;
        r_k          <= n_k;
        r_pk         <= n_pk;
        r_min        <= n_min;
        r_best       <= n_best;
        r_found      <= n_found;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_rgb    <= n_res_rgb;
        if ((r_state == S_DONE) && out_free) begin
            r_status  <= r_res_status;
            r_value   <= r_res_value;
            r_rgb_out <= r_res_rgb;
        end
    end

    pea_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLORS)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (add_sum),
        .i_raddr (ref_raddr),
        .o_rdata (ref_q)
    );

    pea_ram #(
        .WIDTH (24),
        .DEPTH (MAX_COLORS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_q)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_red_out   = r_rgb_out[23:16];
    assign o_green_out = r_rgb_out[15:8];
    assign o_blue_out  = r_rgb_out[7:0];

endmodule

[hdl/pea_checker.sv]
// Port-level checks of the palette entry allocator, bound to the top level.
`include "assert_macros.svh"

module pea_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_status,
    input logic [8:0] o_value,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out
);

    // A pending result stays until it is taken.
    `PEA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its value.
    `PEA_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_value))

    // The block works on one word at a time.
    `PEA_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)

    // A failed action reports no value and no colour.
    `PEA_ASSERT_NOW(a_error_clean, o_out_valid && o_status,
        (o_value == 9'd0) && (o_red_out == 8'd0) && (o_green_out == 8'd0) && (o_blue_out == 8'd0))

endmodule

bind palette_entry_allocator pea_checker u_pea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_value     (o_value),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
